// ----- src/rsltab_pkg.sv -----
// ----------------------------------------------------------------------------
// rsltab_pkg
// Shared field types and operation/status codes of the request slot table.
// ----------------------------------------------------------------------------
package rsltab_pkg;

   // field types of one request word and one response word
   typedef logic [1:0]  action_type;
   typedef logic [15:0] req_id_type;
   typedef logic [1:0]  status_type;
   typedef logic [3:0]  slot_type;

   // operation codes
   localparam action_type ACT_ADD   = 2'd0;
   localparam action_type ACT_GET   = 2'd1;
   localparam action_type ACT_ERASE = 2'd2;

   // response status codes
   localparam status_type STAT_DONE    = 2'd0;
   localparam status_type STAT_NOMATCH = 2'd1;
   localparam status_type STAT_FULL    = 2'd2;

   // width of the reported slot field
   localparam int SLOT_FIELD_W = 4;

endpackage

// ----- src/rsltab_if.sv -----
// ----------------------------------------------------------------------------
// rsltab_if
// Valid/ready channels of the request slot table: request and response.
// ----------------------------------------------------------------------------
interface rsltab_req_if
   import rsltab_pkg::*;
();
   logic       valid;
   logic       ready;
   action_type action;
   req_id_type lookup_id;

   modport source (output valid, output action, output lookup_id, input ready);
   modport sink   (input valid, input action, input lookup_id, output ready);
endinterface

interface rsltab_rsp_if
   import rsltab_pkg::*;
();
   logic       valid;
   logic       ready;
   status_type status;
   slot_type   slot;

   modport source (output valid, output status, output slot, input ready);
   modport sink   (input valid, input status, input slot, output ready);
endinterface

// ----- src/rsltab_id_ram.sv -----
// ----------------------------------------------------------------------------
// rsltab_id_ram
// Id store of the slot table: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rsltab_id_ram
   import rsltab_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  req_id_type    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output req_id_type    rd_data
);

   req_id_type mem [DEPTH];
   req_id_type rd_data_ff;

   // write claimed slot
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read one entry, data valid next cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/request_slot_table.sv -----
// ----------------------------------------------------------------------------
// request_slot_table
// Table of request slots: add claims the lowest free slot, get finds the
// lowest slot holding an id, erase frees every slot holding an id.
// ----------------------------------------------------------------------------
//  channel    dir  handshake       payload
//  req_chan   in   valid/ready     action[1:0], lookup_id[15:0]
//  rsp_chan   out  valid/ready     status[1:0], slot[3:0]
//
//  One word at a time. The id memory is scanned one slot per cycle through
//  its single read port. Add and get end the scan at the first free or
//  matching slot, misses and erase scan every slot, and action 3 goes
//  straight to a no-match response; then the response waits for
//  rsp_chan.ready, and the table returns to idle before the next request.
//  Valid marks are flip-flops cleared by reset; the id memory needs no clear.
//  req_chan.ready is high only while no word is in progress.
// ----------------------------------------------------------------------------
module request_slot_table
   import rsltab_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  logic         clock,
   input  logic         reset,
   rsltab_req_if.sink   req_chan,
   rsltab_rsp_if.source rsp_chan
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOTS - 1);
   localparam logic [IDX_W:0]   SLOTS_CNT = (IDX_W + 1)'(SLOTS);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [SLOTS-1:0] valid_ff, valid_in;
   logic [IDX_W:0]   cnt_ff, cnt_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] first_ff, first_in;
   action_type       act_ff;
   req_id_type       id_ff;
   status_type       status_ff, status_in;
   logic [IDX_W-1:0] ridx_ff, ridx_in;

   logic             accept;
   logic             issue;
   logic             hit;
   logic             free;
   logic             last;
   logic             wr_en;
   req_id_type       rd_data;
   logic [IDX_W+3:0] slot_pad;

   assign accept = req_chan.valid && req_chan.ready;
   assign issue  = (state_ff == ST_SCAN) && (cnt_ff < SLOTS_CNT);

   // id memory
   rsltab_id_ram #(
      .DEPTH (SLOTS),
      .AW    (IDX_W)
   ) u_id_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cmp_idx_ff),
      .wr_data (id_ff),
      .rd_en   (issue),
      .rd_addr (cnt_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // compare the entry read last cycle
   assign hit  = valid_ff[cmp_idx_ff] && (rd_data == id_ff);
   assign free = !valid_ff[cmp_idx_ff];
   assign last = (cmp_idx_ff == LAST_IDX);

   // scan sequencer
   always_comb begin
      state_in   = state_ff;
      valid_in   = valid_ff;
      cnt_in     = cnt_ff;
      cmp_vld_in = 1'b0;
      found_in   = found_ff;
      first_in   = first_ff;
      status_in  = status_ff;
      ridx_in    = ridx_ff;
      wr_en      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in   = '0;
            found_in = 1'b0;
            if (accept) begin
               if (req_chan.action == ACT_ADD || req_chan.action == ACT_GET ||
                   req_chan.action == ACT_ERASE) begin
                  state_in = ST_SCAN;
               end else begin
                  status_in = STAT_NOMATCH;
                  ridx_in   = '0;
                  state_in  = ST_RESP;
               end
            end
         end
         ST_SCAN: begin
            if (issue) begin
               cnt_in     = cnt_ff + 1'b1;
               cmp_vld_in = 1'b1;
            end
            if (cmp_vld_ff) begin
               priority case (act_ff)
                  ACT_ADD: begin
                     if (free) begin
                        wr_en                = 1'b1;
                        valid_in[cmp_idx_ff] = 1'b1;
                        status_in            = STAT_DONE;
                        ridx_in              = cmp_idx_ff;
                        state_in             = ST_RESP;
                     end else if (last) begin
                        status_in = STAT_FULL;
                        ridx_in   = '0;
                        state_in  = ST_RESP;
                     end
                  end
                  ACT_GET: begin
                     if (hit) begin
                        status_in = STAT_DONE;
                        ridx_in   = cmp_idx_ff;
                        state_in  = ST_RESP;
                     end else if (last) begin
                        status_in = STAT_NOMATCH;
                        ridx_in   = '0;
                        state_in  = ST_RESP;
                     end
                  end
                  default: begin
                     // erase: drop every matching slot, report the lowest
                     if (hit) begin
                        valid_in[cmp_idx_ff] = 1'b0;
                        if (!found_ff) begin
                           found_in = 1'b1;
                           first_in = cmp_idx_ff;
                        end
                     end
                     if (last) begin
                        if (found_ff || hit) begin
                           status_in = STAT_DONE;
                           ridx_in   = found_ff ? first_ff : cmp_idx_ff;
                        end else begin
                           status_in = STAT_NOMATCH;
                           ridx_in   = '0;
                        end
                        state_in = ST_RESP;
                     end
                  end
               endcase
            end
            if (state_in != ST_SCAN) begin
               cmp_vld_in = 1'b0;
            end
         end
         ST_RESP: begin
            if (rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= '0;
         cmp_vld_ff <= 1'b0;
         found_ff   <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         cmp_vld_ff <= cmp_vld_in;
         found_ff   <= found_in;
         cnt_ff     <= cnt_in;
      end
   end

   // payload: request word, compare index, response word
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff <= req_chan.action;
         id_ff  <= req_chan.lookup_id;
      end
      cmp_idx_ff <= cnt_ff[IDX_W-1:0];
      first_ff   <= first_in;
      status_ff  <= status_in;
      ridx_ff    <= ridx_in;
   end

   // report the low bits of the slot index
   assign slot_pad = {4'b0000, ridx_ff};

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = (state_ff == ST_RESP);
   assign rsp_chan.status = status_ff;
   assign rsp_chan.slot   = slot_pad[SLOT_FIELD_W-1:0];

`ifndef SYNTHESIS
   // a known operation always starts a scan
   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_chan.action == ACT_ADD || req_chan.action == ACT_GET ||
                  req_chan.action == ACT_ERASE)) |=> (state_ff == ST_SCAN))
      else $error("known operation did not start a scan");

   // at most one slot is claimed per cycle
   a_one_claim: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ($countones(valid_ff) <= $countones($past(valid_ff)) + 1))
      else $error("more than one slot claimed in a cycle");

   // full is reported only when every slot is taken
   a_full_all: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status == STAT_FULL) |-> (&valid_ff))
      else $error("full reported with a free slot");

   // a failed operation reports slot zero
   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status != STAT_DONE) |-> (rsp_chan.slot == '0))
      else $error("nonzero slot on a failed operation");

   // an id write always marks its slot valid
   a_write_valid: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> valid_ff[$past(cmp_idx_ff)])
      else $error("id written without claiming the slot");
`endif

endmodule
